// File: src/dsa_pkg.sv
// Shared types and constants of the descriptor slot allocator.
package dsa_pkg;

	localparam int WORD_BITS = 32;   // used marks per bitmap row
	localparam int LOG_WORD  = 5;
	localparam int SLOT_W    = 10;
	localparam int HEAP_W    = 11;
	localparam int STRIDE_W  = 12;
	localparam int ADDR_W    = 64;
	localparam int PROD_W    = SLOT_W + STRIDE_W;
	localparam int SCAN_W    = 7;    // row counter, holds up to 127 rows
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	localparam logic REQ_FREE = 1'b1;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_FULL      = 2'd1,
		ST_FREED     = 2'd2,
		ST_IGNORED   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAP_SIZE      = 3'd0,
		REG_HANDLE_STRIDE  = 3'd1,
		REG_CPU_BASE       = 3'd2,
		REG_GPU_BASE       = 3'd3,
		REG_SHADER_VISIBLE = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_FREE_RD,
		S_FREE_WR,
		S_MUL,
		S_ADD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] slot_to_free;
		logic              handle_valid;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_index;
		logic [ADDR_W-1:0] host_address;
		logic [ADDR_W-1:0] device_address;
		logic              device_address_valid;
	} out_item_t;

	typedef struct packed {
		logic clr;         // clear one bitmap row
		logic start;       // capture a new transaction
		logic scan;        // issue the next row read of the search
		logic alloc_wr;    // mark the found slot used
		logic set_full;
		logic set_ignored;
		logic free_rd;
		logic free_wr;
		logic mul;
		logic add;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic free_ok;
		logic hit;
		logic exhausted;
		logic out_busy;
	} sts_t;

endpackage

// File: src/descriptor_slot_allocator_unit.sv
// Top level of the descriptor slot allocator: first-fit slot bitmap with handle addresses.
//
//  channel  direction  handshake            payload
//  in       into block in_valid / in_stall   in_item_t  (req_type, slot_to_free, handle_valid)
//  out      from block out_valid / out_stall out_item_t (status, index, addresses)
//  cfg      into block cfg_we               cfg_index, cfg_data
//
// One transaction at a time. Scan rows is ceil(active heap / 32): the bitmap memory gives
// one 32-bit row per cycle. An allocate reads rows until one has a free slot, then forms
// the addresses; a full heap answers once all scan rows are read. A free reads and then
// rewrites the slot's row; an ignored free goes straight to the output. After reset a
// clearing pass writes all ceil(MAX_SLOTS / 32) bitmap rows, one per cycle, in_stall high.
// A result waits in the output register; the next transaction is taken meanwhile.
module descriptor_slot_allocator_unit #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsa_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  dsa_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output dsa_pkg::out_item_t            out_data
);
	import dsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsa_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	// an accepted transaction keeps the input side closed for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in the cycle after a transaction");

	a_dev_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.device_address_valid |-> out_data.status == ST_ALLOCATED)
		else $error("device address on a non-allocate result");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_ALLOCATED |->
		out_data.slot_index == '0 && out_data.host_address == '0 &&
		out_data.device_address == '0)
		else $error("non-allocate result carries slot fields");

endmodule

// File: src/dsa_ctrl.sv
// Controller state machine of the descriptor slot allocator.
module dsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  dsa_pkg::sts_t sts,
	output dsa_pkg::cmd_t cmd
);
	import dsa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!sts.is_free) state_d = S_SCAN;
				else if (sts.free_ok) state_d = S_FREE_RD;
				else state_d = S_OUT;
			end
			S_SCAN: begin
				if (sts.hit) state_d = S_MUL;
				else if (sts.exhausted) state_d = S_OUT;
			end
			S_FREE_RD: state_d = S_FREE_WR;
			S_FREE_WR: state_d = S_OUT;
			S_MUL:     state_d = S_ADD;
			S_ADD:     state_d = S_OUT;
			S_OUT: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.start = in_valid;
			end
			S_DECIDE: cmd.set_ignored = sts.is_free && !sts.free_ok;
			S_SCAN: begin
				cmd.scan = !sts.hit;
				cmd.alloc_wr = sts.hit;
				cmd.set_full = !sts.hit && sts.exhausted;
			end
			S_FREE_RD: cmd.free_rd = 1'b1;
			S_FREE_WR: cmd.free_wr = 1'b1;
			S_MUL:     cmd.mul = 1'b1;
			S_ADD:     cmd.add = 1'b1;
			S_OUT:     cmd.load_out = !sts.out_busy;
			default:   cmd = '0;
		endcase
	end

endmodule

// File: src/dsa_datapath.sv
// Datapath: configuration registers, used-mark bitmap, search, address arithmetic.
module dsa_datapath #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsa_pkg::CFG_W-1:0]         cfg_data,
	input  dsa_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output dsa_pkg::out_item_t                out_data,
	input  dsa_pkg::cmd_t                     cmd,
	output dsa_pkg::sts_t                     sts
);
	import dsa_pkg::*;

	localparam int ROWS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	// configuration
	logic [HEAP_W-1:0]   heap_size_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [ADDR_W-1:0]   cpu_base_q;
	logic [ADDR_W-1:0]   gpu_base_q;
	logic                shader_vis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q  <= HEAP_W'(1024);
			stride_q     <= STRIDE_W'(32);
			cpu_base_q   <= '0;
			gpu_base_q   <= '0;
			shader_vis_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEAP_SIZE:      heap_size_q  <= cfg_data[HEAP_W-1:0];
				REG_HANDLE_STRIDE:  stride_q     <= cfg_data[STRIDE_W-1:0];
				REG_CPU_BASE:       cpu_base_q   <= cfg_data;
				REG_GPU_BASE:       gpu_base_q   <= cfg_data;
				REG_SHADER_VISIBLE: shader_vis_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// active heap limit and number of bitmap rows to search
	logic [HEAP_W-1:0] lim;
	logic [SCAN_W-1:0] scan_rows;

	assign lim = (17'(heap_size_q) > 17'(MAX_SLOTS)) ? HEAP_W'(MAX_SLOTS) : heap_size_q;
	assign scan_rows = SCAN_W'((12'(lim) + 12'(WORD_BITS - 1)) >> LOG_WORD);

	// captured transaction
	in_item_t in_q;

	always_ff @(posedge clk) begin
		if (cmd.start) in_q <= in_data;
	end

	// bitmap memory
	logic [WORD_BITS-1:0] mem [ROWS];
	logic [WORD_BITS-1:0] rdata_s1;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	// search and clear counters
	logic [SCAN_W-1:0]   rd_row_q;
	logic [SCAN_W-1:0]   row_s1;
	logic                rd_vld_s1;
	logic [AW-1:0]       clr_row_q;
	logic                scan_issue;

	logic [AW-1:0]         victim_row;
	logic [LOG_WORD-1:0]   victim_bit;
	logic [11:0]           remain;
	logic [WORD_BITS-1:0]  row_mask;
	logic [WORD_BITS-1:0]  cand;
	logic                  any_free;
	logic [LOG_WORD-1:0]   hit_bit;
	logic [15:0]           hit_idx;

	assign victim_row = AW'(in_q.slot_to_free >> LOG_WORD);
	assign victim_bit = in_q.slot_to_free[LOG_WORD-1:0];
	assign scan_issue = cmd.scan && (rd_row_q < scan_rows);

	// bits of the last row at or beyond the limit are not candidates
	assign remain   = 12'(lim) - (12'(row_s1) << LOG_WORD);
	assign row_mask = (remain >= 12'(WORD_BITS)) ? '1 :
		~({WORD_BITS{1'b1}} << remain[LOG_WORD-1:0]);
	assign cand     = ~rdata_s1 & row_mask;
	assign any_free = |cand;
	assign hit_idx  = (16'(row_s1) << LOG_WORD) | 16'(hit_bit);

	always_comb begin
		hit_bit = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) hit_bit = LOG_WORD'(b);
		end
	end

	always_comb begin
		rd_en   = scan_issue || cmd.free_rd;
		rd_addr = cmd.free_rd ? victim_row : AW'(rd_row_q);
		wr_en   = cmd.clr || cmd.alloc_wr || cmd.free_wr;
		wr_addr = clr_row_q;
		wr_data = '0;
		if (cmd.alloc_wr) begin
			wr_addr = AW'(row_s1);
			wr_data = rdata_s1 | (WORD_BITS'(1) << hit_bit);
		end else if (cmd.free_wr) begin
			wr_addr = victim_row;
			wr_data = rdata_s1 & ~(WORD_BITS'(1) << victim_bit);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
			rd_row_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clr) clr_row_q <= clr_row_q + AW'(1);
			if (cmd.start) begin
				rd_row_q  <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= scan_issue;
				if (scan_issue) rd_row_q <= rd_row_q + SCAN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) row_s1 <= rd_row_q;
	end

	// pending result
	status_t             st_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [PROD_W-1:0]   prod_q;
	logic [ADDR_W-1:0]   host_q;
	logic [ADDR_W-1:0]   dev_q;
	logic                dav_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			st_q   <= ST_ALLOCATED;
			idx_q  <= '0;
			host_q <= '0;
			dev_q  <= '0;
			dav_q  <= 1'b0;
		end
		if (cmd.set_full)    st_q <= ST_FULL;
		if (cmd.set_ignored) st_q <= ST_IGNORED;
		if (cmd.free_wr)     st_q <= ST_FREED;
		if (cmd.alloc_wr) begin
			st_q  <= ST_ALLOCATED;
			idx_q <= hit_idx[SLOT_W-1:0];
		end
		if (cmd.mul) prod_q <= PROD_W'(idx_q) * PROD_W'(stride_q);
		if (cmd.add) begin
			host_q <= cpu_base_q + ADDR_W'(prod_q);
			dev_q  <= shader_vis_q ? gpu_base_q + ADDR_W'(prod_q) : '0;
			dav_q  <= shader_vis_q;
		end
	end

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.status               <= st_q;
			out_q.slot_index           <= idx_q;
			out_q.host_address         <= host_q;
			out_q.device_address       <= dev_q;
			out_q.device_address_valid <= dav_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.clr_last  = (clr_row_q == AW'(ROWS - 1));
	assign sts.is_free   = (in_q.req_type == REQ_FREE);
	assign sts.free_ok   = in_q.handle_valid && (HEAP_W'(in_q.slot_to_free) < lim);
	assign sts.hit       = rd_vld_s1 && any_free;
	assign sts.exhausted = !rd_vld_s1 && (rd_row_q == scan_rows);
	assign sts.out_busy  = out_valid_q && out_stall;

endmodule

// File: bench/descriptor_slot_allocator_unit_tb.sv
// Self-checking testbench of the descriptor slot allocator unit.
module descriptor_slot_allocator_unit_tb;
	import dsa_pkg::*;

	localparam int MAX_SLOTS = 1024;
	localparam int IDLE_PCT = 21;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RUN_LIMIT = 4_000_000;
	localparam logic REQ_ALLOC = ~REQ_FREE;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	// shadow of the block: used marks and register copies
	bit slot_used_m [MAX_SLOTS];
	logic [HEAP_W-1:0] heap_size_m = 11'd1024;
	logic [STRIDE_W-1:0] stride_m = 12'd32;
	logic [ADDR_W-1:0] cpu_base_m = '0;
	logic [ADDR_W-1:0] gpu_base_m = '0;
	logic shader_visible_m = 1'b0;

	out_item_t pending_results [$];
	int errors = 0;
	int n_alloc = 0;
	int n_full = 0;
	int n_freed = 0;
	int n_ignored = 0;
	int n_settings = 0;
	bit idle_en = 1'b1;
	int hold_req = 0;
	int hold_left = 0;

	descriptor_slot_allocator_unit #(.MAX_SLOTS(MAX_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned active_limit();
		return (heap_size_m > HEAP_W'(MAX_SLOTS)) ? MAX_SLOTS : 32'(heap_size_m);
	endfunction

	// first-fit search over the shadow marks; updates them as the block would
	function automatic out_item_t predict_slot_op(input in_item_t req);
		out_item_t res;
		int unsigned lim;
		int unsigned k;
		logic [ADDR_W-1:0] offs;
		res = '0;
		lim = active_limit();
		if (req.req_type != REQ_FREE) begin
			k = 0;
			while (k < lim && slot_used_m[k])
				k++;
			if (k >= lim) begin
				res.status = ST_FULL;
			end else begin
				slot_used_m[k] = 1'b1;
				offs = 64'(k) * 64'(stride_m);
				res.status = ST_ALLOCATED;
				res.slot_index = k[SLOT_W-1:0];
				res.host_address = cpu_base_m + offs;
				if (shader_visible_m) begin
					res.device_address = gpu_base_m + offs;
					res.device_address_valid = 1'b1;
				end
			end
		end else if (!req.handle_valid || req.slot_to_free >= lim) begin
			res.status = ST_IGNORED;
		end else begin
			slot_used_m[req.slot_to_free] = 1'b0;
			res.status = ST_FREED;
		end
		return res;
	endfunction

	task automatic report_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			errors++;
			$display("%0t: result with nothing expected, status %0d slot %0d",
				$time, got.status, got.slot_index);
			return;
		end
		want = pending_results.pop_front();
		report_field("status", 64'(want.status), 64'(got.status));
		report_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
		report_field("host_address", want.host_address, got.host_address);
		report_field("device_address", want.device_address, got.device_address);
		report_field("device_address_valid", 64'(want.device_address_valid),
			64'(got.device_address_valid));
		case (want.status)
			ST_ALLOCATED: n_alloc++;
			ST_FULL:      n_full++;
			ST_FREED:     n_freed++;
			default:      n_ignored++;
		endcase
	endtask

	// both channels observed at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_results.push_back(predict_slot_op(in_data));
			if (out_valid && !out_stall)
				check_result(out_data);
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = idle_en && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// called and returns at a falling edge
	task automatic send_item(input in_item_t item);
		if (idle_en && $urandom_range(0, 99) < IDLE_PCT)
			repeat ($urandom_range(1, 8)) @(negedge clk);
		in_data = item;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_idle(input int settle);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_HEAP_SIZE:      heap_size_m = val[HEAP_W-1:0];
			REG_HANDLE_STRIDE:  stride_m = val[STRIDE_W-1:0];
			REG_CPU_BASE:       cpu_base_m = val;
			REG_GPU_BASE:       gpu_base_m = val;
			REG_SHADER_VISIBLE: shader_visible_m = val[0];
			default: ;
		endcase
	endtask

	function automatic in_item_t make_req(input logic kind, input int unsigned slot,
			input logic handle_ok);
		in_item_t r;
		r.req_type = kind;
		r.slot_to_free = slot[SLOT_W-1:0];
		r.handle_valid = handle_ok;
		return r;
	endfunction

	// mostly allocations and releases of live slots; the rest broken frees
	function automatic in_item_t random_request();
		int unsigned pick;
		int unsigned lim;
		int unsigned live;
		int unsigned nth;
		in_item_t alloc_req;
		pick = $urandom_range(0, 99);
		lim = active_limit();
		alloc_req = make_req(REQ_ALLOC, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
		if (pick < 50)
			return alloc_req;
		if (pick < 85) begin
			live = 0;
			for (int k = 0; k < lim; k++)
				if (slot_used_m[k])
					live++;
			if (live == 0)
				return alloc_req;
			nth = $urandom_range(0, live - 1);
			for (int k = 0; k < lim; k++) begin
				if (slot_used_m[k]) begin
					if (nth == 0)
						return make_req(REQ_FREE, k, 1'b1);
					nth--;
				end
			end
		end
		if (pick < 92)
			return make_req(REQ_FREE, $urandom_range(0, 1023), 1'b0);
		if (pick < 96)
			return make_req(REQ_FREE, $urandom_range(0, (lim == 0) ? 0 : lim - 1), 1'b1);
		return make_req(REQ_FREE, $urandom_range(0, 1023), 1'b1);
	endfunction

	task automatic run_random_items(input int count);
		repeat (count) send_item(random_request());
	endtask

	task automatic random_config(output bit big_heap);
		int unsigned pick;
		logic [CFG_W-1:0] val;
		pick = $urandom_range(0, 99);
		big_heap = (pick >= 90);
		if (pick < 10)
			val = '0;
		else if (pick < 75)
			val = CFG_W'($urandom_range(1, 48));
		else if (pick < 90)
			val = CFG_W'($urandom_range(49, 200));
		else
			val = CFG_W'($urandom_range(1024, 2047));
		write_reg(REG_HEAP_SIZE, val);
		pick = $urandom_range(0, 99);
		val = (pick < 10) ? CFG_W'(0) : (pick < 20) ? CFG_W'(4095) :
			CFG_W'($urandom_range(0, 4095));
		write_reg(REG_HANDLE_STRIDE, val);
		val = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
		write_reg(REG_CPU_BASE, val);
		val = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
		write_reg(REG_GPU_BASE, val);
		write_reg(REG_SHADER_VISIBLE, CFG_W'($urandom_range(0, 1)));
		n_settings++;
	endtask

	// reset register values: allocations, reuse, invalid handle, top index, free of free slot
	task automatic test_directed_ops();
		repeat (3) send_item(make_req(REQ_ALLOC, 0, 1'b0));
		send_item(make_req(REQ_FREE, 1, 1'b1));
		send_item(make_req(REQ_ALLOC, 1023, 1'b1));
		send_item(make_req(REQ_FREE, 5, 1'b1));
		send_item(make_req(REQ_FREE, 2, 1'b0));
		send_item(make_req(REQ_FREE, 1023, 1'b1));
	endtask

	// wrapping addresses, shrunk heap, empty heap, oversized heap, zero stride
	task automatic test_directed_config();
		wait_idle(SETTLE_CYCLES);
		write_reg(REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_F000);
		write_reg(REG_GPU_BASE, '1);
		write_reg(REG_HANDLE_STRIDE, CFG_W'(4095));
		write_reg(REG_SHADER_VISIBLE, CFG_W'(1));
		repeat (2) send_item(make_req(REQ_ALLOC, 1023, 1'b1));
		wait_idle(SETTLE_CYCLES);
		write_reg(REG_HEAP_SIZE, CFG_W'(4));
		send_item(make_req(REQ_ALLOC, 0, 1'b0));
		send_item(make_req(REQ_FREE, 4, 1'b1));
		send_item(make_req(REQ_FREE, 3, 1'b1));
		repeat (2) send_item(make_req(REQ_ALLOC, 0, 1'b0));
		wait_idle(SETTLE_CYCLES);
		write_reg(REG_HEAP_SIZE, CFG_W'(0));
		send_item(make_req(REQ_ALLOC, 0, 1'b0));
		send_item(make_req(REQ_FREE, 0, 1'b1));
		wait_idle(SETTLE_CYCLES);
		write_reg(REG_HEAP_SIZE, CFG_W'(2047));
		write_reg(REG_HANDLE_STRIDE, CFG_W'(0));
		send_item(make_req(REQ_ALLOC, 0, 1'b0));
		wait_idle(SETTLE_CYCLES);
		write_reg(REG_SHADER_VISIBLE, CFG_W'(0));
		send_item(make_req(REQ_ALLOC, 0, 1'b0));
	endtask

	task automatic test_random_phases();
		bit big_heap;
		for (int p = 0; p < 9; p++) begin
			wait_idle(SETTLE_CYCLES);
			random_config(big_heap);
			run_random_items(big_heap ? 20 : 65);
		end
	endtask

	// receiver holds off while the sender keeps offering, then sender waits for all
	task automatic test_backpressure();
		wait_idle(SETTLE_CYCLES);
		idle_en = 1'b0;
		hold_req = HOLD_OFF_CYCLES;
		run_random_items(20);
		idle_en = 1'b1;
		wait_idle(SETTLE_CYCLES);
	endtask

	task automatic test_no_idle();
		bit big_heap;
		idle_en = 1'b0;
		random_config(big_heap);
		run_random_items(100);
		idle_en = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_ops();
		test_directed_config();
		test_random_phases();
		test_backpressure();
		test_no_idle();
		wait_idle(DRAIN_CYCLES);
		$display("checked %0d results: %0d allocated, %0d full, %0d freed, %0d ignored",
			n_alloc + n_full + n_freed + n_ignored, n_alloc, n_full, n_freed, n_ignored);
		$display("random register settings applied: %0d", n_settings);
		if (errors == 0)
			$display("descriptor_slot_allocator_unit_tb: done, clean");
		else
			$display("descriptor_slot_allocator_unit_tb: done, errors");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("descriptor_slot_allocator_unit_tb: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
src/dsa_pkg.sv
src/dsa_ctrl.sv
src/dsa_datapath.sv
src/descriptor_slot_allocator_unit.sv
bench/descriptor_slot_allocator_unit_tb.sv
